[hdl/mrc_pkg.sv]
// Shared definitions for the Modbus response checker.
// Function codes, verdict codes, table codes and the per-byte result struct.
// No dependencies.
package mrc_pkg;

  // Modbus function codes this checker knows
  localparam logic [7:0] FC_READ_COILS     = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
  localparam logic [7:0] FC_READ_INPUT     = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
  localparam logic [7:0] FC_WRITE_REG      = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS     = 8'd16;
  localparam logic [7:0] FC_READ_WRITE_REG = 8'd23;

  // Verdict codes
  localparam logic [2:0] VERDICT_PASS        = 3'd0;
  localparam logic [2:0] VERDICT_FUNCTION    = 3'd1;
  localparam logic [2:0] VERDICT_LENGTH      = 3'd2;
  localparam logic [2:0] VERDICT_QUANTITY    = 3'd3;
  localparam logic [2:0] VERDICT_VALUE       = 3'd4;
  localparam logic [2:0] VERDICT_ADDRESS     = 3'd5;
  localparam logic [2:0] VERDICT_ADDR_QTY    = 3'd6;
  localparam logic [2:0] VERDICT_UNSUPPORTED = 3'd7;

  // Target table codes
  localparam logic [1:0] TABLE_COILS    = 2'd0;
  localparam logic [1:0] TABLE_DISCRETE = 2'd1;
  localparam logic [1:0] TABLE_HOLDING  = 2'd2;
  localparam logic [1:0] TABLE_INPUT    = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] CFG_FUNCTION = 8'd0;
  localparam logic [7:0] CFG_QUANTITY = 8'd1;
  localparam logic [7:0] CFG_ADDRESS  = 8'd2;
  localparam logic [7:0] CFG_VALUE    = 8'd3;

  // Byte position counter
  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  // PDU length of a write echo: function, address, value/quantity
  localparam logic [POS_W:0] ECHO_LEN = 10'd5;

  typedef struct packed {
    logic       is_payload;
    logic [2:0] verdict;
    logic [1:0] target_table;
    logic       is_write;
  } mrc_res_t;

endpackage

[hdl/mrc_check.sv]
// Per-byte evaluation for the Modbus response checker: payload mark and,
// on the final byte, verdict, target table and write flag.
// Depends on mrc_pkg.
module mrc_check import mrc_pkg::*; (
  input  logic [7:0]       exp_function_i,
  input  logic [15:0]      exp_quantity_i,
  input  logic [15:0]      exp_address_i,
  input  logic [15:0]      exp_value_i,
  input  logic [7:0]       seen_function_i,
  input  logic [15:0]      first_word_i,
  input  logic [15:0]      second_word_i,
  input  logic [POS_W-1:0] pos_i,
  input  logic             last_i,
  output mrc_res_t         res_o
);

  logic [7:0]     count;
  logic [POS_W:0] len;
  logic           len_ok_read;
  logic           len_ok_echo;
  logic [10:0]    bits;
  logic [2:0]     verdict;
  logic [1:0]     table_code;
  logic           wr;
  logic           payload;

  assign count       = first_word_i[15:8];
  assign len         = {1'b0, pos_i} + 10'd1;
  assign len_ok_read = (len == (10'd2 + {2'b00, count}));
  assign len_ok_echo = (len == ECHO_LEN);
  assign bits        = {count, 3'b000};

  always_comb begin
    if (seen_function_i != exp_function_i) begin
      verdict = VERDICT_FUNCTION;
    end else begin
      case (exp_function_i) inside
        FC_READ_COILS, FC_READ_DISCRETE: begin
          if (!len_ok_read)                      verdict = VERDICT_LENGTH;
          else if ({5'd0, bits} < exp_quantity_i) verdict = VERDICT_QUANTITY;
          else                                   verdict = VERDICT_PASS;
        end
        FC_READ_HOLDING, FC_READ_INPUT, FC_READ_WRITE_REG: begin
          if (!len_ok_read)                                  verdict = VERDICT_LENGTH;
          else if ({9'd0, count[7:1]} != exp_quantity_i)    verdict = VERDICT_QUANTITY;
          else                                               verdict = VERDICT_PASS;
        end
        FC_WRITE_COIL, FC_WRITE_REG: begin
          if (!len_ok_echo)                        verdict = VERDICT_LENGTH;
          else if (second_word_i != exp_value_i)   verdict = VERDICT_VALUE;
          else if (first_word_i != exp_address_i)  verdict = VERDICT_ADDRESS;
          else                                     verdict = VERDICT_PASS;
        end
        FC_WRITE_COILS, FC_WRITE_REGS: begin
          if (!len_ok_echo) verdict = VERDICT_LENGTH;
          else if (first_word_i != exp_address_i || second_word_i != exp_quantity_i)
            verdict = VERDICT_ADDR_QTY;
          else verdict = VERDICT_PASS;
        end
        default: verdict = VERDICT_UNSUPPORTED;
      endcase
    end
  end

  always_comb begin
    case (exp_function_i) inside
      FC_READ_DISCRETE: table_code = TABLE_DISCRETE;
      FC_READ_HOLDING, FC_WRITE_REG, FC_WRITE_REGS, FC_READ_WRITE_REG:
        table_code = TABLE_HOLDING;
      FC_READ_INPUT: table_code = TABLE_INPUT;
      default: table_code = TABLE_COILS;
    endcase
  end

  always_comb begin
    case (exp_function_i) inside
      FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: wr = 1'b1;
      default: wr = 1'b0;
    endcase
  end

  // Consumer data: read data after function and byte count for codes 1 to 4,
  // or the value of a single write echo.
  always_comb begin
    case (exp_function_i) inside
      FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT:
        payload = (pos_i >= 9'd2);
      FC_WRITE_COIL, FC_WRITE_REG:
        payload = (pos_i == 9'd3) || (pos_i == 9'd4);
      default: payload = 1'b0;
    endcase
  end

  assign res_o.is_payload   = payload;
  assign res_o.verdict      = last_i ? verdict : VERDICT_PASS;
  assign res_o.target_table = last_i ? table_code : TABLE_COILS;
  assign res_o.is_write     = last_i & wr;

endmodule

[hdl/modbus_response_checker_top.sv]
// Top level of the Modbus response checker: input register, PDU capture
// state, result register and configuration registers.
// Depends on mrc_pkg and mrc_check.
//
//  channel | handshake                  | word
//  --------+----------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o    | data_byte_i, last_byte_i, station_i
//  out     | out_valid_o / out_ready_i  | out_byte_o .. station_out_o
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Two register stages: an input register and a result register, with the
// checks as short compares between them; each word passes both in turn.
// One word per cycle sustained while the output is not stalled.
// Reset clears the position counter, captured fields, config and valids.
// A stalled output holds the result register; the input register still
// takes a word while it is empty, so one word waits behind a stall.
// Config is always ready and must only be written while the block is idle.
module modbus_response_checker_top import mrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  station_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_payload_o,
  output logic        done_res_o,
  output logic [2:0]  verdict_o,
  output logic [1:0]  target_table_o,
  output logic        is_write_o,
  output logic [7:0]  station_out_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers
  logic [7:0]  exp_function_q;
  logic [15:0] exp_quantity_q;
  logic [15:0] exp_address_q;
  logic [15:0] exp_value_q;

  // Input register
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic [7:0]  s1_station_q;

  // PDU capture state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       seen_function_q, seen_function_d;
  logic [15:0]      first_word_q, first_word_d;
  logic [15:0]      second_word_q, second_word_d;

  // Result register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_payload_q;
  logic        out_done_q;
  logic [2:0]  out_verdict_q;
  logic [1:0]  out_table_q;
  logic        out_write_q;
  logic [7:0]  out_station_q;

  logic     advance;
  logic     in_fire;
  mrc_res_t res;

  // Stage 1 moves into the result register when that register is free.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_function_q <= '0;
      exp_quantity_q <= '0;
      exp_address_q  <= '0;
      exp_value_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FUNCTION: exp_function_q <= cfg_data_i[7:0];
        CFG_QUANTITY: exp_quantity_q <= cfg_data_i;
        CFG_ADDRESS:  exp_address_q  <= cfg_data_i;
        CFG_VALUE:    exp_value_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q    <= data_byte_i;
      s1_last_q    <= last_byte_i;
      s1_station_q <= station_i;
    end
  end

  // Capture of function code, first word (address or byte count) and second
  // word (value or quantity). Fields are cleared on the function byte so a
  // short PDU compares against zeros.
  always_comb begin
    seen_function_d = seen_function_q;
    first_word_d    = first_word_q;
    second_word_d   = second_word_q;
    case (pos_q)
      9'd0: begin
        seen_function_d = s1_byte_q;
        first_word_d    = '0;
        second_word_d   = '0;
      end
      9'd1: first_word_d[15:8]  = s1_byte_q;
      9'd2: first_word_d[7:0]   = s1_byte_q;
      9'd3: second_word_d[15:8] = s1_byte_q;
      9'd4: second_word_d[7:0]  = s1_byte_q;
      default: ;
    endcase
  end

  // Position returns to zero after the final byte and saturates otherwise.
  always_comb begin
    if (s1_last_q) begin
      pos_d = '0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 9'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q           <= '0;
      seen_function_q <= '0;
      first_word_q    <= '0;
      second_word_q   <= '0;
    end else if (advance) begin
      pos_q           <= pos_d;
      seen_function_q <= seen_function_d;
      first_word_q    <= first_word_d;
      second_word_q   <= second_word_d;
    end
  end

  // Checks run on the fields including the byte now in stage 1.
  mrc_check u_check (
    .exp_function_i  (exp_function_q),
    .exp_quantity_i  (exp_quantity_q),
    .exp_address_i   (exp_address_q),
    .exp_value_i     (exp_value_q),
    .seen_function_i (seen_function_d),
    .first_word_i    (first_word_d),
    .second_word_i   (second_word_d),
    .pos_i           (pos_q),
    .last_i          (s1_last_q),
    .res_o           (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q    <= s1_byte_q;
      out_payload_q <= res.is_payload;
      out_done_q    <= s1_last_q;
      out_verdict_q <= res.verdict;
      out_table_q   <= res.target_table;
      out_write_q   <= res.is_write;
      out_station_q <= s1_station_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign is_payload_o   = out_payload_q;
  assign done_res_o     = out_done_q;
  assign verdict_o      = out_verdict_q;
  assign target_table_o = out_table_q;
  assign is_write_o     = out_write_q;
  assign station_out_o  = out_station_q;

endmodule

[tb/sv/mrc_pdu_checker.sv]
// Checker for the Modbus response checker: watches the config, input and result
// channels, predicts every result word and compares it field by field.
// Depends on mrc_pkg.
module mrc_pdu_checker import mrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  station_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        is_payload_i,
  input  logic        done_res_i,
  input  logic [2:0]  verdict_i,
  input  logic [1:0]  target_table_i,
  input  logic        is_write_i,
  input  logic [7:0]  station_out_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatches_o,
  output int          pending_o
);

  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [7:0] data_b;
    logic       payload;
    logic       done;
    logic [2:0] verdict;
    logic [1:0] tbl;
    logic       wr;
    logic [7:0] stn;
  } pdu_byte_t;

  // pending request
  logic [7:0]       want_fc;
  logic [15:0]      want_qty, want_addr, want_val;
  // captured PDU fields
  logic [POS_W-1:0] pos;
  logic [7:0]       seen_fc;
  logic [15:0]      word_a, word_b;

  pdu_byte_t expected_bytes[$];
  int        errors = 0;

  assign mismatches_o = errors;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic logic payload_for(input logic [7:0] fc, input logic [POS_W-1:0] p);
    case (fc)
      FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: return p >= 2;
      FC_WRITE_COIL, FC_WRITE_REG: return (p == 3) || (p == 4);
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [1:0] table_for(input logic [7:0] fc);
    case (fc)
      FC_READ_DISCRETE: return TABLE_DISCRETE;
      FC_READ_HOLDING, FC_WRITE_REG, FC_WRITE_REGS, FC_READ_WRITE_REG: return TABLE_HOLDING;
      FC_READ_INPUT: return TABLE_INPUT;
      default: return TABLE_COILS;
    endcase
  endfunction

  function automatic logic write_code(input logic [7:0] fc);
    case (fc)
      FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // verdict of a complete PDU of len bytes against the pending request
  function automatic logic [2:0] judge_pdu(input logic [POS_W:0] len);
    int unsigned count;
    count = word_a[15:8];
    if (seen_fc != want_fc) return VERDICT_FUNCTION;
    case (want_fc)
      FC_READ_COILS, FC_READ_DISCRETE: begin
        if (len != count + 2) return VERDICT_LENGTH;
        if (count * 8 < want_qty) return VERDICT_QUANTITY;
        return VERDICT_PASS;
      end
      FC_READ_HOLDING, FC_READ_INPUT, FC_READ_WRITE_REG: begin
        if (len != count + 2) return VERDICT_LENGTH;
        if (count / 2 != want_qty) return VERDICT_QUANTITY;
        return VERDICT_PASS;
      end
      FC_WRITE_COIL, FC_WRITE_REG: begin
        if (len != ECHO_LEN) return VERDICT_LENGTH;
        if (word_b != want_val) return VERDICT_VALUE;
        if (word_a != want_addr) return VERDICT_ADDRESS;
        return VERDICT_PASS;
      end
      FC_WRITE_COILS, FC_WRITE_REGS: begin
        if (len != ECHO_LEN) return VERDICT_LENGTH;
        if (word_a != want_addr || word_b != want_qty) return VERDICT_ADDR_QTY;
        return VERDICT_PASS;
      end
      default: return VERDICT_UNSUPPORTED;
    endcase
  endfunction

  task automatic predict_pdu_byte(input logic [7:0] b, input logic last,
                                  input logic [7:0] stn, output pdu_byte_t res);
    logic [POS_W:0] len;
    case (pos)
      0: begin
        seen_fc = b;
        word_a  = '0;
        word_b  = '0;
      end
      1: word_a[15:8] = b;
      2: word_a[7:0]  = b;
      3: word_b[15:8] = b;
      4: word_b[7:0]  = b;
      default: ;
    endcase
    res = '{data_b: b, payload: payload_for(want_fc, pos), done: last,
            verdict: VERDICT_PASS, tbl: TABLE_COILS, wr: 1'b0, stn: stn};
    if (last) begin
      len         = {1'b0, pos} + 1'b1;
      res.verdict = judge_pdu(len);
      res.tbl     = table_for(want_fc);
      res.wr      = write_code(want_fc);
      pos         = '0;
    end else if (pos != POS_MAX) begin
      pos = pos + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pdu_byte_t want, got;
    if (!rst_ni) begin
      want_fc   = '0;
      want_qty  = '0;
      want_addr = '0;
      want_val  = '0;
      pos       = '0;
      seen_fc   = '0;
      word_a    = '0;
      word_b    = '0;
      expected_bytes.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FUNCTION: want_fc   = cfg_data_i[7:0];
          CFG_QUANTITY: want_qty  = cfg_data_i;
          CFG_ADDRESS:  want_addr = cfg_data_i;
          CFG_VALUE:    want_val  = cfg_data_i;
          default: ;
        endcase
      end
      // results first: a word accepted this edge cannot show up this edge
      if (out_valid_i && out_ready_i) begin
        got = '{data_b: out_byte_i, payload: is_payload_i, done: done_res_i,
                verdict: verdict_i, tbl: target_table_i, wr: is_write_i,
                stn: station_out_i};
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected result word, out_byte", got.data_b, '0);
        end else begin
          want = expected_bytes.pop_front();
          if (got.data_b !== want.data_b)   report_mismatch("out_byte", got.data_b, want.data_b);
          if (got.payload !== want.payload) report_mismatch("is_payload", got.payload, want.payload);
          if (got.done !== want.done)       report_mismatch("done_res", got.done, want.done);
          if (got.verdict !== want.verdict) report_mismatch("verdict", got.verdict, want.verdict);
          if (got.tbl !== want.tbl)         report_mismatch("target_table", got.tbl, want.tbl);
          if (got.wr !== want.wr)           report_mismatch("is_write", got.wr, want.wr);
          if (got.stn !== want.stn)         report_mismatch("station_out", got.stn, want.stn);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_pdu_byte(data_byte_i, last_byte_i, station_i, want);
        expected_bytes.push_back(want);
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the Modbus response checker: clock, reset, request
// programming, response PDU stimulus and the final verdict.
// Depends on mrc_pkg, modbus_response_checker_top and mrc_pdu_checker.
module tb_top import mrc_pkg::*; ();

  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_GOAL     = 1450;
  localparam int PHASE_WORDS   = 40;    // words per request setting
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int LONG_PDU      = 514;   // runs the position counter into saturation
  localparam int PRESSURE_PHASE = 5;
  localparam int QUIET_PHASE    = 7;
  localparam int LONG_PHASE     = 3;
  localparam logic [7:0] EXCEPTION_BIT = 8'h80;

  typedef logic [7:0] byte_q_t[$];

  // ways to damage an otherwise well-formed response
  typedef enum int {
    SPOIL_FC, SPOIL_EXCEPTION, SPOIL_COUNT, SPOIL_SHORT, SPOIL_LONG, SPOIL_FIELD
  } spoil_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data = '0;
  logic        in_last = 1'b0;
  logic [7:0]  in_station = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_payload, out_done, out_write;
  logic [2:0]  out_verdict;
  logic [1:0]  out_table;
  logic [7:0]  out_station;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = CFG_FUNCTION;
  logic [15:0] cfg_data = '0;

  int mismatches, pending;
  int sent = 0;        // input words accepted so far
  int cycles = 0;
  bit quiet = 1'b0;    // no idling on either side
  bit hold_out = 1'b0; // ask the receiver for one long hold-off

  // request as last programmed, used to shape well-formed responses
  logic [7:0]  cur_fc = '0;
  logic [15:0] cur_qty = '0, cur_addr = '0, cur_val = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modbus_response_checker_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (in_data),
    .last_byte_i    (in_last),
    .station_i      (in_station),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .is_payload_o   (out_payload),
    .done_res_o     (out_done),
    .verdict_o      (out_verdict),
    .target_table_o (out_table),
    .is_write_o     (out_write),
    .station_out_o  (out_station),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  mrc_pdu_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .data_byte_i    (in_data),
    .last_byte_i    (in_last),
    .station_i      (in_station),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_i     (out_byte),
    .is_payload_i   (out_payload),
    .done_res_i     (out_done),
    .verdict_i      (out_verdict),
    .target_table_i (out_table),
    .is_write_i     (out_write),
    .station_out_i  (out_station),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[modbus_response_checker_top] ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, none while quiet. On request it holds
  // off for a long stretch so the block fills and stalls its input side.
  always begin : receiver
    @(posedge clk);
    if (hold_out) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_out = 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 25);
    end
  end

  // One input word; valid stays up until taken, then maybe a short gap.
  task automatic send_word(input logic [7:0] b, input logic last, input logic [7:0] stn);
    in_valid   <= 1'b1;
    in_data    <= b;
    in_last    <= last;
    in_station <= stn;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic send_pdu(input byte_q_t pdu, input logic [7:0] stn);
    foreach (pdu[i]) send_word(pdu[i], i == pdu.size() - 1, stn);
  endtask

  // Drop valid and wait until every result word has come back, with some
  // margin. pending is a registered copy of the queue size, hence the
  // first wait.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program the pending request; only ever done with the block idle.
  task automatic apply_request(input logic [7:0] fc, input logic [15:0] qty,
                               input logic [15:0] addr, input logic [15:0] val);
    drain();
    cur_fc = fc;
    cur_qty = qty;
    cur_addr = addr;
    cur_val = val;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FUNCTION;
    cfg_data  <= {8'h00, fc};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_QUANTITY;
    cfg_data  <= qty;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ADDRESS;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_VALUE;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A response that should pass against the current request, where one can.
  task automatic build_response(output byte_q_t pdu);
    int unsigned n;
    pdu = {};
    pdu.push_back(cur_fc);
    case (cur_fc)
      FC_READ_COILS, FC_READ_DISCRETE: begin
        n = (cur_qty + 7) / 8;
        if ($urandom_range(99) < 30) n += $urandom_range(1, 3);  // extra bytes still pass
        if (n > 255) n = $urandom_range(0, 255);
        pdu.push_back(8'(n));
        repeat (n) pdu.push_back(8'($urandom));
      end
      FC_READ_HOLDING, FC_READ_INPUT, FC_READ_WRITE_REG: begin
        n = 2 * cur_qty + $urandom_range(0, 1);  // odd count rounds down
        if (n > 255) n = $urandom_range(0, 255);
        pdu.push_back(8'(n));
        repeat (n) pdu.push_back(8'($urandom));
      end
      FC_WRITE_COIL, FC_WRITE_REG: begin
        pdu.push_back(cur_addr[15:8]);
        pdu.push_back(cur_addr[7:0]);
        pdu.push_back(cur_val[15:8]);
        pdu.push_back(cur_val[7:0]);
      end
      FC_WRITE_COILS, FC_WRITE_REGS: begin
        pdu.push_back(cur_addr[15:8]);
        pdu.push_back(cur_addr[7:0]);
        pdu.push_back(cur_qty[15:8]);
        pdu.push_back(cur_qty[7:0]);
      end
      default: repeat ($urandom_range(0, 6)) pdu.push_back(8'($urandom));
    endcase
  endtask

  task automatic spoil_response(ref byte_q_t pdu);
    spoil_e kind;
    int     idx;
    kind = spoil_e'($urandom_range(0, 5));
    case (kind)
      SPOIL_FC:        pdu[0] = pdu[0] ^ 8'($urandom_range(1, 255));
      SPOIL_EXCEPTION: pdu = {cur_fc | EXCEPTION_BIT, 8'($urandom_range(1, 4))};
      SPOIL_COUNT:     if (pdu.size() > 1) pdu[1] = 8'($urandom);
      SPOIL_SHORT:     repeat ($urandom_range(1, 3)) if (pdu.size() > 1) void'(pdu.pop_back());
      SPOIL_LONG:      repeat ($urandom_range(1, 3)) pdu.push_back(8'($urandom));
      SPOIL_FIELD: begin
        if (pdu.size() > 1) begin
          idx = $urandom_range(1, (pdu.size() > 5) ? 4 : pdu.size() - 1);
          pdu[idx] = pdu[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
      end
      default: ;
    endcase
  endtask

  // Zero, all ones, or anything in between.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] code_for_phase(input int p);
    case (p % 10)
      0: return FC_READ_COILS;
      1: return FC_READ_DISCRETE;
      2: return FC_READ_HOLDING;
      3: return FC_READ_INPUT;
      4: return FC_WRITE_COIL;
      5: return FC_WRITE_REG;
      6: return FC_WRITE_COILS;
      7: return FC_WRITE_REGS;
      8: return FC_READ_WRITE_REG;
      default: begin
        // unsupported codes, extremes included
        case ($urandom_range(0, 2))
          0: return 8'h00;
          1: return 8'hFF;
          default: return 8'($urandom_range(24, 254));
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    byte_q_t     pdu;
    int          phase;
    int          first;
    int          r;
    logic [7:0]  fc;
    logic [15:0] qty;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reset leaves function code 0: unsupported.
    send_pdu('{8'h00}, 8'd0);

    apply_request(FC_READ_HOLDING, 16'd2, 16'h0000, 16'h0000);
    send_pdu('{8'h03, 8'h04, 8'h00, 8'hFF, 8'h80, 8'h7F}, 8'd0);  // clean read
    send_pdu('{8'h03}, 8'd247);                                   // short PDU
    send_pdu('{8'h83, 8'h02}, 8'hA5);                             // exception reply

    apply_request(FC_WRITE_COIL, 16'hFFFF, 16'hFFFF, 16'hFF00);
    send_pdu('{8'h05, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 8'h5A);        // clean echo
    send_pdu('{8'h05, 8'hFF, 8'hFF, 8'h00, 8'h00}, 8'd1);         // value off
    send_pdu('{8'h05, 8'h00, 8'h00, 8'hFF, 8'h00}, 8'd128);       // address off

    // Random part: one request setting per phase, mostly well-formed
    // responses with random content, the rest damaged or plain noise.
    phase = 0;
    while (sent < ITEM_GOAL) begin
      fc = code_for_phase(phase);
      case (fc)
        FC_READ_COILS, FC_READ_DISCRETE:
          qty = ($urandom_range(9) == 0) ? pick_word() : 16'($urandom_range(0, 60));
        FC_READ_HOLDING, FC_READ_INPUT, FC_READ_WRITE_REG:
          qty = ($urandom_range(9) == 0) ? pick_word() : 16'($urandom_range(0, 12));
        default: qty = pick_word();
      endcase
      apply_request(fc, qty, pick_word(), pick_word());
      quiet = (phase == QUIET_PHASE);
      if (phase == PRESSURE_PHASE) hold_out = 1'b1;
      first = sent;

      if (phase == LONG_PHASE) begin
        build_response(pdu);
        while (pdu.size() < LONG_PDU) pdu.push_back(8'($urandom));
        send_pdu(pdu, 8'($urandom_range(0, 247)));
      end

      while (sent - first < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 10) begin
          pdu = {};
          repeat ($urandom_range(1, 8)) pdu.push_back(8'($urandom));
        end else begin
          build_response(pdu);
          if (r < 40) spoil_response(pdu);
        end
        send_pdu(pdu, 8'($urandom_range(0, 247)));
      end
      phase++;
    end

    quiet = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[modbus_response_checker_top] OK");
    end else begin
      $display("[modbus_response_checker_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mrc_pkg.sv
hdl/mrc_check.sv
hdl/modbus_response_checker_top.sv
tb/sv/mrc_pdu_checker.sv
tb/sv/tb_top.sv
